FILE: sv/clt_pkg.sv
// Shared types and codes for the character LCD terminal controller.
`default_nettype none
package clt_pkg;

  // Parser modes of the byte classifier
  typedef enum logic [2:0] {
    PM_NORMAL, PM_SKIP, PM_ESC, PM_ROW, PM_COL, PM_SLOT, PM_GLYPH
  } pmode_t;

  // Commands handed from the classifier to the executor
  typedef enum logic [4:0] {
    OP_NOP, OP_PUT, OP_BS, OP_TAB, OP_NL, OP_CR, OP_UP, OP_DOWN, OP_RIGHT,
    OP_LEFT, OP_HOME, OP_CLEAR, OP_ERASE, OP_ROW, OP_COL, OP_GROW, OP_GLAST
  } op_t;

  // Executor states
  typedef enum logic [2:0] {
    B_IDLE, B_EXEC, B_SRC, B_SWAIT, B_PRD, B_PCMP, B_GLY, B_DONE
  } bstate_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] arg;
    logic [2:0] idx;   // glyph row index or glyph slot
  } cmd_t;

  typedef struct packed {
    logic       iv;
    logic [7:0] ib;
    logic       dv;
    logic [7:0] db;
  } res_t;

  localparam int QDEPTH = 4;

  // Configuration port
  localparam int CFG_IW = 1;
  localparam int CFG_DW = 5;
  localparam logic [CFG_IW-1:0] REG_ROWS = 1'b0;
  localparam logic [CFG_IW-1:0] REG_COLS = 1'b1;

  // Terminal bytes
  localparam logic [7:0] CH_EOT   = 8'h04;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_ESC   = 8'h1b;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] ESC_UP    = 8'h41;
  localparam logic [7:0] ESC_DOWN  = 8'h42;
  localparam logic [7:0] ESC_RIGHT = 8'h43;
  localparam logic [7:0] ESC_LEFT  = 8'h44;
  localparam logic [7:0] ESC_HOME  = 8'h48;
  localparam logic [7:0] ESC_CLEAR = 8'h4a;
  localparam logic [7:0] ESC_ERASE = 8'h4b;
  localparam logic [7:0] ESC_ADDR  = 8'h59;
  localparam logic [7:0] ESC_GLYPH = 8'h52;
  localparam logic [7:0] ADDR_BIAS = 8'h1f;

  // Panel instructions and address map
  localparam logic [7:0] SET_DDRAM = 8'h80;
  localparam logic [7:0] SET_CGRAM = 8'h40;
  localparam logic [7:0] INS_CLEAR = 8'h01;
  localparam int ROW_LINE = 'h40;
  localparam int ROW2_OFS = 'h14;
  // Single-row 16-column panels are split in two halves at column 8
  localparam int SPLIT_COLS = 16;
  localparam int SPLIT_COL  = 8;

endpackage
`default_nettype wire

FILE: sv/clt_front.sv
// Byte classifier: tracks escape parsing and turns each byte into a command.
`default_nettype none
module clt_front import clt_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,
  output logic            push,
  output cmd_t            push_cmd,
  input  wire logic       q_full
);

  pmode_t     mode, mode_next;
  logic [2:0] slot, slot_next;
  logic [2:0] gcnt, gcnt_next;
  logic       is_digit;

  assign s_tready = !q_full;
  assign push     = s_tvalid && !q_full;
  assign is_digit = (s_tdata >= CH_ZERO) && (s_tdata <= CH_SEVEN);

  // Classify the byte under the current mode
  always_comb begin
    mode_next    = mode;
    slot_next    = slot;
    gcnt_next    = gcnt;
    push_cmd.op  = OP_NOP;
    push_cmd.arg = s_tdata;
    push_cmd.idx = 3'd0;
    case (mode)
      PM_NORMAL: begin
        priority case (s_tdata)
          CH_EOT: push_cmd.op = OP_NOP;
          CH_BS:  push_cmd.op = OP_BS;
          CH_TAB: push_cmd.op = OP_TAB;
          CH_LF:  push_cmd.op = OP_NL;
          CH_CR:  push_cmd.op = OP_CR;
          CH_ESC: mode_next = PM_SKIP;
          default: push_cmd.op = OP_PUT;
        endcase
      end
      PM_SKIP: mode_next = PM_ESC;
      PM_ESC: begin
        mode_next = PM_NORMAL;
        if (is_digit) begin
          push_cmd.op  = OP_PUT;
          push_cmd.arg = {5'd0, s_tdata[2:0]};
        end else begin
          priority case (s_tdata)
            ESC_UP:    push_cmd.op = OP_UP;
            ESC_DOWN:  push_cmd.op = OP_DOWN;
            ESC_RIGHT: push_cmd.op = OP_RIGHT;
            ESC_LEFT:  push_cmd.op = OP_LEFT;
            ESC_HOME:  push_cmd.op = OP_HOME;
            ESC_CLEAR: push_cmd.op = OP_CLEAR;
            ESC_ERASE: push_cmd.op = OP_ERASE;
            ESC_ADDR:  mode_next = PM_ROW;
            ESC_GLYPH: mode_next = PM_SLOT;
            default:   push_cmd.op = OP_NOP;
          endcase
        end
      end
      PM_ROW: begin
        push_cmd.op = OP_ROW;
        mode_next   = PM_COL;
      end
      PM_COL: begin
        push_cmd.op = OP_COL;
        mode_next   = PM_NORMAL;
      end
      PM_SLOT: begin
        if (is_digit) begin
          slot_next = s_tdata[2:0];
          gcnt_next = 3'd0;
          mode_next = PM_GLYPH;
        end else begin
          mode_next = PM_NORMAL;
        end
      end
      PM_GLYPH: begin
        if (gcnt == 3'd7) begin
          push_cmd.op  = OP_GLAST;
          push_cmd.idx = slot;
          gcnt_next    = 3'd0;
          mode_next    = PM_NORMAL;
        end else begin
          push_cmd.op  = OP_GROW;
          push_cmd.idx = gcnt;
          gcnt_next    = gcnt + 3'd1;
        end
      end
      default: mode_next = PM_NORMAL;
    endcase
  end

  // Advance parser state on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= PM_NORMAL;
      slot <= 3'd0;
      gcnt <= 3'd0;
    end else if (push) begin
      mode <= mode_next;
      slot <= slot_next;
      gcnt <= gcnt_next;
    end
  end

endmodule
`default_nettype wire

FILE: sv/clt_queue.sv
// Short command queue between classifier and executor.
`default_nettype none
module clt_queue import clt_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      full,
  input  wire logic pop,
  output cmd_t      pop_cmd,
  output logic      empty
);

  localparam int PW = $clog2(QDEPTH);

  cmd_t          slots [QDEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [PW:0]   count;

  assign full    = (count == (PW+1)'(QDEPTH));
  assign empty   = (count == '0);
  assign pop_cmd = slots[rd_ptr];

  // Store entries
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_cmd;
  end

  // Move pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PW'(1);
      if (pop)  rd_ptr <= rd_ptr + PW'(1);
      if (push && !pop)      count <= count + (PW+1)'(1);
      else if (pop && !push) count <= count - (PW+1)'(1);
    end
  end

endmodule
`default_nettype wire

FILE: sv/clt_back.sv
// Command executor: screen shadow, cursors and panel write generation.
`default_nettype none
module clt_back import clt_pkg::*; #(
  parameter int MAX_ROWS  = 4,
  parameter int MAX_COLS  = 16,
  parameter int TAB_WIDTH = 3
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        q_empty,
  output logic             q_pop,
  input  wire cmd_t        q_cmd,
  input  wire logic [2:0]  rows_in_use,
  input  wire logic [4:0]  cols_in_use,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,
  output logic             m_tlast
);

  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW    = $clog2(MAX_COLS);
  localparam int NW    = $clog2(MAX_COLS + 1);
  localparam int RNW   = $clog2(MAX_ROWS + 1);
  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);

  bstate_t        state, state_next;
  op_t            op;
  logic [7:0]     arg;
  logic [2:0]     idx;
  logic [RW-1:0]  crow, pr, sr, panel_row, crow_cl;
  logic [CW-1:0]  ccol, pc, sj, ccol_cl;
  logic [NW-1:0]  panel_col;
  logic           known;
  logic [7:0]     pch;
  logic [2:0]     gk;
  logic [7:0]     grow [8];
  logic [7:0]     mem [DEPTH];
  logic [DEPTH-1:0] vbits;
  logic [7:0]     mem_rd;
  logic           v_rd;
  logic           pend_v, out_v, out_last;
  res_t           pend, out_res, emit_res;
  logic           emit_req, flush_req, stall, out_free;
  logic [RNW-1:0] rows_n;
  logic [NW-1:0]  cols_n;
  logic [RW-1:0]  rows_last;
  logic [CW-1:0]  cols_last;
  logic [AW-1:0]  rd_addr, dst_addr;
  logic [7:0]     cur, adj;
  logic           changed, need_addr;
  logic [6:0]     ddram;
  logic [6:0]     tab_tbl [MAX_COLS];

  // Clamp configured size into the fitted range
  always_comb begin
    if (rows_in_use == 3'd0)           rows_n = RNW'(1);
    else if (int'(rows_in_use) > MAX_ROWS) rows_n = RNW'(MAX_ROWS);
    else                               rows_n = RNW'(rows_in_use);
    if (cols_in_use == 5'd0)           cols_n = NW'(1);
    else if (int'(cols_in_use) > MAX_COLS) cols_n = NW'(MAX_COLS);
    else                               cols_n = NW'(cols_in_use);
  end
  assign rows_last = RW'(rows_n - RNW'(1));
  assign cols_last = CW'(cols_n - NW'(1));
  assign crow_cl   = (crow > rows_last) ? rows_last : crow;
  assign ccol_cl   = (ccol > cols_last) ? cols_last : ccol;

  // Next tab stop for each column
  for (genvar k = 0; k < MAX_COLS; k++) begin : g_tab
    localparam int TS = ((k + 1) / TAB_WIDTH) * TAB_WIDTH + TAB_WIDTH - 1;
    assign tab_tbl[k] = 7'(TS);
  end

  // Shadow addressing and compare
  assign dst_addr = AW'(int'(pr) * MAX_COLS + int'(pc));
  assign rd_addr  = (state == B_SRC) ? AW'((int'(sr) + 1) * MAX_COLS + int'(sj)) : dst_addr;
  assign cur      = v_rd ? mem_rd : CH_SPACE;
  assign changed  = (cur != pch);
  assign ddram    = (int'(pr) >= 2)
                  ? 7'((int'(pr) - 2) * ROW_LINE + int'(pc) + ROW2_OFS)
                  : 7'(int'(pr) * ROW_LINE + int'(pc));
  assign need_addr = !known || (panel_row != pr) || (panel_col != NW'(pc)) ||
                     ((rows_n == RNW'(1)) && (int'(cols_n) == SPLIT_COLS) &&
                      (int'(pc) == SPLIT_COL));
  assign adj = arg - ADDR_BIAS;

  // Result generation
  always_comb begin
    emit_req  = 1'b0;
    flush_req = 1'b0;
    emit_res  = '0;
    unique case (state)
      B_EXEC: begin
        if (op == OP_CLEAR) begin
          emit_req    = 1'b1;
          emit_res.iv = 1'b1;
          emit_res.ib = INS_CLEAR;
        end
      end
      B_PCMP: begin
        emit_req    = changed;
        emit_res.iv = need_addr;
        emit_res.ib = need_addr ? (SET_DDRAM | {1'b0, ddram}) : 8'd0;
        emit_res.dv = 1'b1;
        emit_res.db = pch;
      end
      B_GLY: begin
        emit_req    = 1'b1;
        emit_res.iv = (gk == 3'd0);
        emit_res.ib = (gk == 3'd0) ? (SET_CGRAM | {2'b00, idx, 3'b000}) : 8'd0;
        emit_res.dv = 1'b1;
        emit_res.db = grow[gk];
      end
      B_DONE: flush_req = pend_v;
      B_IDLE, B_SRC, B_SWAIT, B_PRD: ;
    endcase
  end
  assign out_free = !out_v || m_tready;
  assign stall    = (emit_req || flush_req) && pend_v && !out_free;
  assign q_pop    = (state == B_IDLE) && !q_empty;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: if (!q_empty) state_next = B_EXEC;
      B_EXEC: begin
        priority case (op)
          OP_PUT, OP_ERASE: state_next = B_PRD;
          OP_BS:    state_next = (ccol != '0) ? B_PRD : B_DONE;
          OP_NL:    state_next = (crow < rows_last) ? B_DONE : B_SRC;
          OP_CLEAR: state_next = stall ? B_EXEC : B_DONE;
          OP_GLAST: state_next = B_GLY;
          default:  state_next = B_DONE;
        endcase
      end
      B_SRC:  state_next = (sr == rows_last) ? B_PRD : B_SWAIT;
      B_SWAIT: state_next = B_PRD;
      B_PRD:  state_next = B_PCMP;
      B_PCMP: begin
        if (!stall) begin
          if (op == OP_NL)
            state_next = ((sj == cols_last) && (sr == rows_last)) ? B_DONE : B_SRC;
          else if (op == OP_ERASE)
            state_next = (pc == cols_last) ? B_DONE : B_PRD;
          else
            state_next = B_DONE;
        end
      end
      B_GLY:  if (!stall && gk == 3'd7) state_next = B_DONE;
      B_DONE: if (!stall) state_next = B_IDLE;
    endcase
  end

  // Shadow memory with registered read
  always_ff @(posedge clk) begin
    if (state == B_PCMP && changed && !stall) mem[dst_addr] <= pch;
    mem_rd <= mem[rd_addr];
    v_rd   <= vbits[rd_addr];
  end

  // Written-cell flags: unwritten cells read as space
  always_ff @(posedge clk) begin
    if (rst) vbits <= '0;
    else if (state == B_EXEC && op == OP_CLEAR && !stall) vbits <= '0;
    else if (state == B_PCMP && changed && !stall) vbits[dst_addr] <= 1'b1;
  end

  // Glyph row buffer
  always_ff @(posedge clk) begin
    if (state == B_EXEC && op == OP_GROW)  grow[idx] <= arg;
    if (state == B_EXEC && op == OP_GLAST) grow[7]   <= arg;
  end

  // Command registers and sweep counters
  always_ff @(posedge clk) begin
    if (q_pop) begin
      op  <= q_cmd.op;
      arg <= q_cmd.arg;
      idx <= q_cmd.idx;
    end
    unique case (state)
      B_EXEC: begin
        pr  <= crow;
        pc  <= (op == OP_BS) ? ccol - CW'(1) : ccol;
        pch <= (op == OP_PUT) ? arg : CH_SPACE;
        sr  <= '0;
        sj  <= '0;
        gk  <= 3'd0;
      end
      B_SRC: begin
        pr  <= sr;
        pc  <= sj;
        pch <= CH_SPACE;
      end
      B_SWAIT: pch <= cur;
      B_PCMP: begin
        if (!stall) begin
          if (op == OP_ERASE) pc <= pc + CW'(1);
          if (sj == cols_last) begin
            sj <= '0;
            sr <= sr + RW'(1);
          end else begin
            sj <= sj + CW'(1);
          end
        end
      end
      B_GLY: if (!stall) gk <= gk + 3'd1;
      B_IDLE, B_PRD, B_DONE: ;
    endcase
  end

  // Cursors, panel position and state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      crow      <= '0;
      ccol      <= '0;
      panel_row <= '0;
      panel_col <= '0;
      known     <= 1'b1;
    end else begin
      state <= state_next;
      if (q_pop) begin
        crow <= crow_cl;
        ccol <= ccol_cl;
      end
      if (state == B_EXEC) begin
        unique case (op)
          OP_BS:    if (ccol != '0) ccol <= ccol - CW'(1);
          OP_TAB:   ccol <= (tab_tbl[ccol] >= 7'(cols_n)) ? cols_last
                                                          : CW'(tab_tbl[ccol]);
          OP_NL:    if (crow < rows_last) crow <= crow + RW'(1);
          OP_CR:    ccol <= '0;
          OP_UP:    if (crow != '0) crow <= crow - RW'(1);
          OP_DOWN:  if (crow < rows_last) crow <= crow + RW'(1);
          OP_RIGHT: if (ccol < cols_last) ccol <= ccol + CW'(1);
          OP_LEFT:  if (ccol != '0) ccol <= ccol - CW'(1);
          OP_HOME: begin
            crow <= '0;
            ccol <= '0;
          end
          OP_CLEAR: if (!stall) begin
            panel_row <= '0;
            panel_col <= '0;
            known     <= 1'b1;
          end
          OP_ROW: begin
            if (arg < ADDR_BIAS)                     crow <= '0;
            else if (adj >= 8'(rows_n))              crow <= rows_last;
            else                                     crow <= RW'(adj);
          end
          OP_COL: begin
            if (arg < ADDR_BIAS)                     ccol <= '0;
            else if (adj >= 8'(cols_n))              ccol <= cols_last;
            else                                     ccol <= CW'(adj);
          end
          OP_NOP, OP_PUT, OP_ERASE, OP_GROW, OP_GLAST: ;
        endcase
      end
      if (state == B_PCMP && !stall) begin
        if (changed) begin
          if (need_addr) begin
            panel_row <= pr;
            panel_col <= NW'(pc) + NW'(1);
            known     <= 1'b1;
          end else begin
            panel_col <= panel_col + NW'(1);
          end
        end
        if (op == OP_PUT && pc < cols_last) ccol <= ccol + CW'(1);
      end
      if (state == B_GLY && !stall && gk == 3'd7) known <= 1'b0;
    end
  end

  // Hold one result back so the final one can carry last
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_v <= 1'b0;
      out_v  <= 1'b0;
    end else begin
      if (emit_req && !stall) begin
        pend_v <= 1'b1;
        if (pend_v) out_v <= 1'b1;
        else if (m_tready) out_v <= 1'b0;
      end else if (flush_req && !stall) begin
        pend_v <= 1'b0;
        out_v  <= 1'b1;
      end else if (m_tready) begin
        out_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_req && !stall) begin
      pend <= emit_res;
      if (pend_v) begin
        out_res  <= pend;
        out_last <= 1'b0;
      end
    end else if (flush_req && !stall) begin
      out_res  <= pend;
      out_last <= 1'b1;
    end
  end

  assign m_tvalid = out_v;
  assign m_tlast  = out_last;
  assign m_tdata  = {6'd0, out_res.db, out_res.dv, out_res.ib, out_res.iv};

endmodule
`default_nettype wire

FILE: sv/char_lcd_terminal_controller.sv
// Top level of the character LCD terminal controller.
//
//  channel  direction  beat contents
//  s_*      in         tdata[7:0] in_byte
//  m_*      out        tdata: instr_valid, instr_byte, data_valid, data_byte; tlast last
//  cfg_*    in         cfg_index selects register, cfg_data[4:0] value
//
// A byte is classified as it is accepted and queued; the executor walks a
// character write through its EXEC, PRD, PCMP and DONE states. A scroll walks
// the screen shadow through its single read port, moving each cell up one row,
// then blanks the bottom row; an erase to end of line passes PRD and PCMP per cell.
// Reset is synchronous; after it the shadow reads as all spaces at once.
// The input stalls only when the command queue is full; the executor stalls
// while the output register is held by the sink.
`default_nettype none
module char_lcd_terminal_controller import clt_pkg::*; #(
  parameter int MAX_ROWS  = 4,
  parameter int MAX_COLS  = 16,
  parameter int TAB_WIDTH = 3
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [7:0]        s_tdata,   // [7:0] in_byte
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [23:0]            m_tdata,   // [0] instr_valid, [8:1] instr_byte,
                                            // [9] data_valid, [17:10] data_byte
  output logic                   m_tlast,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CFG_IW-1:0] cfg_index,
  input  wire logic [CFG_DW-1:0] cfg_data
);

  logic [2:0] rows_in_use;
  logic [4:0] cols_in_use;
  logic       push, q_full, q_empty, q_pop;
  cmd_t       push_cmd, q_cmd;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= 3'd2;
      cols_in_use <= 5'd16;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ROWS: rows_in_use <= cfg_data[2:0];
        REG_COLS: cols_in_use <= cfg_data[4:0];
      endcase
    end
  end

  clt_front u_front (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata,
    .push, .push_cmd, .q_full
  );

  clt_queue u_queue (
    .clk, .rst, .push, .push_cmd, .full(q_full),
    .pop(q_pop), .pop_cmd(q_cmd), .empty(q_empty)
  );

  clt_back #(
    .MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS), .TAB_WIDTH(TAB_WIDTH)
  ) u_back (
    .clk, .rst, .q_empty, .q_pop, .q_cmd, .rows_in_use, .cols_in_use,
    .m_tvalid, .m_tready, .m_tdata, .m_tlast
  );

endmodule
`default_nettype wire
